FILE: src/plsu_pkg.sv
// shared types and constants for the positional list store unit
`timescale 1ns / 1ps

package plsu_pkg;

    localparam int DEF_MAX_ENTRIES = 64;
    localparam int DEF_ENTRY_WIDTH = 32;

    localparam int CMD_W  = 3;
    localparam int POS_W  = 7;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT   = 3'd0,
        CMD_DELETE   = 3'd1,
        CMD_RETRIEVE = 3'd2,
        CMD_REPLACE  = 3'd3,
        CMD_CLEAR    = 3'd4
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef struct packed {
        logic             ins;
        logic             del;
        logic             rep;
        logic [POS_W-1:0] pos;
    } t_cell_ctrl;

endpackage

FILE: src/plsu_cell.sv
// one list slot: holds an entry and shifts with its neighbors
`timescale 1ns / 1ps

module plsu_cell #(
    parameter int INDEX       = 0,
    parameter int ENTRY_WIDTH = plsu_pkg::DEF_ENTRY_WIDTH
) (
    input  logic                   i_clk,
    input  plsu_pkg::t_cell_ctrl   i_ctrl,
    input  logic [ENTRY_WIDTH-1:0] i_value,
    input  logic [ENTRY_WIDTH-1:0] i_below,
    input  logic [ENTRY_WIDTH-1:0] i_above,
    output logic [ENTRY_WIDTH-1:0] o_data,
    output logic [ENTRY_WIDTH-1:0] o_sel
);

    logic [ENTRY_WIDTH-1:0] r_data;
    logic [ENTRY_WIDTH-1:0] n_data;
    logic                   match;
    logic                   after;

    assign match = (int'(i_ctrl.pos) == INDEX);
    assign after = (int'(i_ctrl.pos) < INDEX);

    always_comb begin
        n_data = r_data;
        if (i_ctrl.ins) begin
            if (match) begin
                n_data = i_value;
            end else if (after) begin
                n_data = i_below;
            end
        end else if (i_ctrl.del) begin
            if (match || after) begin
                n_data = i_above;
            end
        end else if (i_ctrl.rep && match) begin
            n_data = i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_sel  = match ? r_data : '0;

endmodule

FILE: src/positional_list_store_unit.sv
// top level of the positional list store unit
//
//  channel   direction  transfer when        signals
//  command   in         start && !busy       i_command, i_position, i_element_value
//  result    out        o_valid (one cycle)  o_read_value, o_status, o_entry_count_out,
//                                            o_is_empty, o_is_full
//
// one command per cycle; its result appears on the cycle after the transfer
// the row of cells shifts every later entry in the same cycle as the command
// busy stays low, so a new command may follow in every cycle
// synchronous active-low reset empties the list; entry contents are not cleared
// the receiver cannot stall: each result is shown for exactly one cycle
`timescale 1ns / 1ps

module positional_list_store_unit #(
    parameter int MAX_ENTRIES = plsu_pkg::DEF_MAX_ENTRIES,
    parameter int ENTRY_WIDTH = plsu_pkg::DEF_ENTRY_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [plsu_pkg::CMD_W-1:0]  i_command,
    input  logic [plsu_pkg::POS_W-1:0]  i_position,
    input  logic [plsu_pkg::VAL_W-1:0]  i_element_value,
    output logic                        o_valid,
    output logic [plsu_pkg::VAL_W-1:0]  o_read_value,
    output logic [plsu_pkg::STAT_W-1:0] o_status,
    output logic [plsu_pkg::CNT_W-1:0]  o_entry_count_out,
    output logic                        o_is_empty,
    output logic                        o_is_full
);

    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int CMPW = (CW > plsu_pkg::POS_W) ? CW : plsu_pkg::POS_W;

    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic                   r_valid;
    logic [plsu_pkg::VAL_W-1:0] r_read_value;
    logic [plsu_pkg::VAL_W-1:0] n_read_value;
    plsu_pkg::t_status      r_status;
    plsu_pkg::t_status      n_status;

    plsu_pkg::t_cell_ctrl   ctrl;
    logic                   accept;
    logic                   full;
    logic [CMPW-1:0]        cnt_x;
    logic [CMPW-1:0]        pos_x;
    logic [ENTRY_WIDTH-1:0] value;
    logic [ENTRY_WIDTH-1:0] sel_data;

    logic [ENTRY_WIDTH-1:0] cell_data [MAX_ENTRIES];
    logic [ENTRY_WIDTH-1:0] cell_sel  [MAX_ENTRIES];
    logic [ENTRY_WIDTH-1:0] below     [MAX_ENTRIES];
    logic [ENTRY_WIDTH-1:0] above     [MAX_ENTRIES];

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (r_count == CW'(MAX_ENTRIES));
    assign cnt_x  = CMPW'(r_count);
    assign pos_x  = CMPW'(i_position);
    assign value  = ENTRY_WIDTH'(i_element_value);

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cells
        if (g == 0) begin : g_first
            assign below[g] = '0;
        end else begin : g_rest
            assign below[g] = cell_data[g-1];
        end
        if (g == MAX_ENTRIES - 1) begin : g_last
            assign above[g] = cell_data[g];
        end else begin : g_inner
            assign above[g] = cell_data[g+1];
        end

        plsu_cell #(
            .INDEX       (g),
            .ENTRY_WIDTH (ENTRY_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (ctrl),
            .i_value (value),
            .i_below (below[g]),
            .i_above (above[g]),
            .o_data  (cell_data[g]),
            .o_sel   (cell_sel[g])
        );
    end

    always_comb begin
        sel_data = '0;
        for (int k = 0; k < MAX_ENTRIES; k++) begin
            sel_data = sel_data | cell_sel[k];
        end
    end

    always_comb begin
        ctrl         = '0;
        ctrl.pos     = i_position;
        n_count      = r_count;
        n_status     = plsu_pkg::ST_OK;
        n_read_value = '0;
        case (plsu_pkg::t_cmd'(i_command))
            plsu_pkg::CMD_INSERT: begin
                if (full) begin
                    n_status = plsu_pkg::ST_FULL;
                end else if (pos_x > cnt_x) begin
                    n_status = plsu_pkg::ST_RANGE;
                end else begin
                    ctrl.ins = accept;
                    n_count  = r_count + CW'(1);
                end
            end
            plsu_pkg::CMD_DELETE, plsu_pkg::CMD_RETRIEVE, plsu_pkg::CMD_REPLACE: begin
                if (r_count == '0) begin
                    n_status = plsu_pkg::ST_EMPTY;
                end else if (pos_x >= cnt_x) begin
                    n_status = plsu_pkg::ST_RANGE;
                end else if (plsu_pkg::t_cmd'(i_command) == plsu_pkg::CMD_DELETE) begin
                    ctrl.del     = accept;
                    n_count      = r_count - CW'(1);
                    n_read_value = plsu_pkg::VAL_W'(sel_data);
                end else if (plsu_pkg::t_cmd'(i_command) == plsu_pkg::CMD_RETRIEVE) begin
                    n_read_value = plsu_pkg::VAL_W'(sel_data);
                end else begin
                    ctrl.rep = accept;
                end
            end
            plsu_pkg::CMD_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept;
            if (accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_read_value <= n_read_value;
            r_status     <= n_status;
        end
    end

    assign o_valid           = r_valid;
    assign o_read_value      = r_read_value;
    assign o_status          = r_status;
    assign o_entry_count_out = plsu_pkg::CNT_W'(r_count);
    assign o_is_empty        = (r_count == '0);
    assign o_is_full         = full;

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ENTRIES))
        else $error("entry count above capacity");

    a_result_follows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_valid)
        else $error("no result after command transfer");

    a_error_keeps_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != plsu_pkg::ST_OK) |-> $stable(r_count))
        else $error("count changed on an error result");

    a_count_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_count != '0) |->
        (r_count == $past(r_count) || r_count == $past(r_count) + CW'(1) ||
         r_count == $past(r_count) - CW'(1)))
        else $error("count moved by more than one");

endmodule

FILE: verif/list_store_checker.sv
// checker that predicts and compares every transfer of the positional list store unit
`timescale 1ns / 1ps

module list_store_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic [plsu_pkg::CMD_W-1:0]  i_command,
    input  logic [plsu_pkg::POS_W-1:0]  i_position,
    input  logic [plsu_pkg::VAL_W-1:0]  i_element_value,
    input  logic                        o_valid,
    input  logic [plsu_pkg::VAL_W-1:0]  o_read_value,
    input  logic [plsu_pkg::STAT_W-1:0] o_status,
    input  logic [plsu_pkg::CNT_W-1:0]  o_entry_count_out,
    input  logic                        o_is_empty,
    input  logic                        o_is_full,
    output int                          err_count,
    output int                          pending
);
    import plsu_pkg::*;

    localparam int LIST_DEPTH = DEF_MAX_ENTRIES;

    typedef struct packed {
        logic [VAL_W-1:0] read_value;
        t_status          status;
        logic [CNT_W-1:0] count;
        logic             empty;
        logic             full;
    } t_list_reply;

    logic [VAL_W-1:0] list_mem [LIST_DEPTH];
    int               list_len;
    t_list_reply      replies_due [$];
    t_list_reply      due;

    initial begin
        err_count = 0;
        pending   = 0;
        list_len  = 0;
    end

    function automatic t_list_reply model_list_command(logic [CMD_W-1:0] cmd,
                                                       logic [POS_W-1:0] pos,
                                                       logic [VAL_W-1:0] val);
        t_list_reply r;
        int          i;
        r.read_value = '0;
        r.status     = ST_OK;
        case (cmd)
            CMD_INSERT: begin
                if (list_len >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else if (int'(pos) > list_len) begin
                    r.status = ST_RANGE;
                end else begin
                    for (i = list_len; i > int'(pos); i--) list_mem[i] = list_mem[i-1];
                    list_mem[int'(pos)] = val;
                    list_len++;
                end
            end
            CMD_DELETE, CMD_RETRIEVE, CMD_REPLACE: begin
                if (list_len == 0) begin
                    r.status = ST_EMPTY;
                end else if (int'(pos) >= list_len) begin
                    r.status = ST_RANGE;
                end else if (cmd == CMD_REPLACE) begin
                    list_mem[int'(pos)] = val;
                end else begin
                    r.read_value = list_mem[int'(pos)];
                    if (cmd == CMD_DELETE) begin
                        for (i = int'(pos) + 1; i < list_len; i++) list_mem[i-1] = list_mem[i];
                        list_len--;
                    end
                end
            end
            CMD_CLEAR: begin
                list_len = 0;
            end
            default: begin
            end
        endcase
        r.count = list_len[CNT_W-1:0];
        r.empty = (list_len == 0);
        r.full  = (list_len >= LIST_DEPTH);
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            list_len = 0;
            replies_due.delete();
        end else begin
            if (start && !busy) begin
                replies_due.push_back(model_list_command(i_command, i_position,
                                                         i_element_value));
            end
            if (o_valid) begin
                if (replies_due.size() == 0) begin
                    err_count++;
                    $display("%0t: result with no transfer pending", $time);
                end else begin
                    due = replies_due.pop_front();
                    if (o_read_value !== due.read_value) begin
                        err_count++;
                        $display("%0t: read_value expected %h actual %h",
                                 $time, due.read_value, o_read_value);
                    end
                    if (o_status !== due.status) begin
                        err_count++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, due.status, o_status);
                    end
                    if (o_entry_count_out !== due.count) begin
                        err_count++;
                        $display("%0t: entry_count_out expected %0d actual %0d",
                                 $time, due.count, o_entry_count_out);
                    end
                    if (o_is_empty !== due.empty) begin
                        err_count++;
                        $display("%0t: is_empty expected %b actual %b",
                                 $time, due.empty, o_is_empty);
                    end
                    if (o_is_full !== due.full) begin
                        err_count++;
                        $display("%0t: is_full expected %b actual %b",
                                 $time, due.full, o_is_full);
                    end
                end
            end
        end
        pending = replies_due.size();
    end

endmodule

FILE: verif/tb.sv
// top-level testbench with stimulus and verdict for the positional list store unit
`timescale 1ns / 1ps

module tb;
    import plsu_pkg::*;

    localparam int LIST_DEPTH  = DEF_MAX_ENTRIES;
    localparam int RAND_OPS    = 1750;
    localparam int CALM_TAIL   = 200;
    localparam int SEG_LEN     = 120;
    localparam int CYCLE_LIMIT = 200000;

    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_C = 3'd7;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BLEND, MIX_NOISE} t_mix;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [CMD_W-1:0]   i_command;
    logic [POS_W-1:0]   i_position;
    logic [VAL_W-1:0]   i_element_value;
    logic               o_valid;
    logic [VAL_W-1:0]   o_read_value;
    logic [STAT_W-1:0]  o_status;
    logic [CNT_W-1:0]   o_entry_count_out;
    logic               o_is_empty;
    logic               o_is_full;
    int                 err_count;
    int                 pending;
    int                 fill_level;
    int                 cycle_count;

    positional_list_store_unit u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_command         (i_command),
        .i_position        (i_position),
        .i_element_value   (i_element_value),
        .o_valid           (o_valid),
        .o_read_value      (o_read_value),
        .o_status          (o_status),
        .o_entry_count_out (o_entry_count_out),
        .o_is_empty        (o_is_empty),
        .o_is_full         (o_is_full)
    );

    list_store_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_command         (i_command),
        .i_position        (i_position),
        .i_element_value   (i_element_value),
        .o_valid           (o_valid),
        .o_read_value      (o_read_value),
        .o_status          (o_status),
        .o_entry_count_out (o_entry_count_out),
        .o_is_empty        (o_is_empty),
        .o_is_full         (o_is_full),
        .err_count         (err_count),
        .pending           (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // result of the previous transfer is visible at the falling edge
    task automatic next_fall();
        @(negedge i_clk);
        if (o_valid) fill_level = int'(o_entry_count_out);
    endtask

    task automatic issue(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val);
        start           <= 1'b1;
        i_command       <= cmd;
        i_position      <= pos;
        i_element_value <= val;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic send_op(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val);
        next_fall();
        issue(cmd, pos, val);
    endtask

    task automatic idle_burst(int cycles);
        repeat (cycles) begin
            next_fall();
            start <= 1'b0;
        end
    endtask

    function automatic logic [POS_W-1:0] pick_position(logic [CMD_W-1:0] cmd);
        int r;
        int top;
        r   = $urandom_range(99);
        top = (cmd == CMD_INSERT) ? fill_level : fill_level - 1;
        if (r < 80) return (top < 0) ? '0 : POS_W'($urandom_range(top, 0));
        if (r < 88) begin
            case ($urandom_range(2))
                0:       return POS_W'(fill_level);
                1:       return (fill_level > 0) ? POS_W'(fill_level - 1) : '0;
                default: return '0;
            endcase
        end
        if (r < 95) return POS_W'($urandom_range(LIST_DEPTH, fill_level));
        return POS_W'($urandom_range(2**POS_W - 1));
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(19);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return VAL_W'($urandom);
    endfunction

    function automatic logic [CMD_W-1:0] pick_command(t_mix mix);
        int r;
        r = $urandom_range(99);
        case (mix)
            MIX_FILL: begin
                if (r < 85) return CMD_INSERT;
                if (r < 90) return CMD_RETRIEVE;
                if (r < 95) return CMD_REPLACE;
                return CMD_DELETE;
            end
            MIX_DRAIN: begin
                if (r < 80) return CMD_DELETE;
                if (r < 88) return CMD_RETRIEVE;
                if (r < 95) return CMD_REPLACE;
                if (r < 99) return CMD_INSERT;
                return CMD_CLEAR;
            end
            MIX_BLEND: begin
                if (r < 30) return CMD_INSERT;
                if (r < 55) return CMD_DELETE;
                if (r < 75) return CMD_RETRIEVE;
                if (r < 95) return CMD_REPLACE;
                if (r < 97) return CMD_CLEAR;
                return CMD_W'($urandom_range(CMD_SPARE_C, CMD_SPARE_A));
            end
            default: return CMD_W'($urandom_range(2**CMD_W - 1));
        endcase
    endfunction

    task automatic send_random_op(t_mix mix);
        logic [CMD_W-1:0] cmd;
        logic [POS_W-1:0] pos;
        next_fall();
        cmd = pick_command(mix);
        if (mix == MIX_NOISE) pos = POS_W'($urandom_range(2**POS_W - 1));
        else                  pos = pick_position(cmd);
        issue(cmd, pos, pick_value());
    endtask

    initial begin
        t_mix mix;
        bit   idle_on;
        int   n;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_command       = CMD_CLEAR;
        i_position      = '0;
        i_element_value = '0;
        fill_level      = 0;
        mix             = MIX_FILL;
        idle_on         = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty list, range checks, append, middle insert, replace and delete
        send_op(CMD_RETRIEVE, 7'd0, 32'h0);
        send_op(CMD_DELETE, 7'd0, 32'h0);
        send_op(CMD_REPLACE, 7'd0, 32'hdeadbeef);
        send_op(CMD_CLEAR, 7'd0, 32'h0);
        send_op(CMD_INSERT, 7'd1, 32'h11111111);
        send_op(CMD_INSERT, 7'd0, 32'h00000000);
        send_op(CMD_INSERT, 7'd1, 32'hffffffff);
        send_op(CMD_INSERT, 7'd1, 32'ha5a5a5a5);
        send_op(CMD_INSERT, 7'd127, 32'h12345678);
        send_op(CMD_RETRIEVE, 7'd0, 32'h0);
        send_op(CMD_RETRIEVE, 7'd1, 32'h0);
        send_op(CMD_RETRIEVE, 7'd2, 32'h0);
        send_op(CMD_RETRIEVE, 7'd3, 32'h0);
        send_op(CMD_RETRIEVE, 7'd127, 32'hffffffff);
        send_op(CMD_REPLACE, 7'd1, 32'h5a5a5a5a);
        send_op(CMD_REPLACE, 7'd3, 32'h87654321);
        send_op(CMD_RETRIEVE, 7'd1, 32'h0);
        send_op(CMD_DELETE, 7'd1, 32'h0);
        send_op(CMD_DELETE, 7'd64, 32'h0);
        send_op(CMD_SPARE_A, 7'd127, 32'hffffffff);
        send_op(CMD_SPARE_B, 7'd0, 32'h0);
        send_op(CMD_SPARE_C, 7'd1, 32'hffffffff);
        send_op(CMD_DELETE, 7'd0, 32'h0);
        send_op(CMD_CLEAR, 7'd0, 32'hffffffff);

        for (n = 0; n < RAND_OPS; n++) begin
            if (n % SEG_LEN == 0) begin
                if (n != 0) mix = t_mix'($urandom_range(3));
                idle_on = ($urandom_range(9) < 7);
            end
            if (idle_on && n < RAND_OPS - CALM_TAIL && $urandom_range(4) == 0)
                idle_burst($urandom_range(14, 1));
            send_random_op(mix);
        end

        next_fall();
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: files.f
src/plsu_pkg.sv
src/plsu_cell.sv
src/positional_list_store_unit.sv
verif/list_store_checker.sv
verif/tb.sv
